// File: rtl/utf8_stream_decoder_top_assert.svh
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Expects signals named clk and rst in the including module.
`ifndef UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`ifndef SYNTH
`define USD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");
`define USD_ASSERT_IMPL(lbl, ante, cons) `USD_ASSERT(lbl, (ante) |-> (cons))
`define USD_ASSERT_NEXT(lbl, ante, cons) `USD_ASSERT(lbl, (ante) |=> (cons))
`else
`define USD_ASSERT(lbl, prop)
`define USD_ASSERT_IMPL(lbl, ante, cons)
`define USD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/usd_pkg.sv
// Types and constants for the UTF-8 stream decoder.
// No dependencies; used by the decode, result queue and top RTL modules of the block.
`default_nettype none

package usd_pkg;

  localparam int CP_W = 21;

  localparam logic [2:0] LEN_ERR = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;

  localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_2BYTE  = 21'h00007F;
  localparam logic [CP_W-1:0] MAX_3BYTE  = 21'h0007FF;
  localparam logic [CP_W-1:0] MAX_BMP    = 21'h00FFFF;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;

  // pending multi-byte sequence
  typedef struct packed {
    logic [2:0]      expected_len;
    logic [1:0]      bytes_seen;
    logic [CP_W-1:0] partial_value;
  } usd_state_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic [2:0]      seq_length;
    logic            is_error;
    logic [15:0]     char_index;
  } usd_result_t;

  // range check on a completed sequence (overlong, surrogate, above max)
  function automatic logic scalar_ok(input logic [CP_W-1:0] v, input logic [2:0] len);
    logic ok;
    ok = 1'b0;
    unique case (len)
      LEN_2:   ok = (v > MAX_2BYTE);
      LEN_3:   ok = (v > MAX_3BYTE) && !((v >= SURR_LO) && (v <= SURR_HI));
      default: ok = (v > MAX_BMP) && (v <= MAX_SCALAR);
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

// File: rtl/usd_decode.sv
// Single-pass byte decode: next sequence state, up to two results and
// the next character count. Depends on usd_pkg.
`default_nettype none

module usd_decode #(
  parameter int COUNT_WIDTH = 16
) (
  input  usd_pkg::usd_state_t  state,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic [COUNT_WIDTH-1:0] counter,
  input  logic [20:0]          replacement_point,
  output usd_pkg::usd_state_t  state_next,
  output logic [COUNT_WIDTH-1:0] counter_next,
  output logic                 res0_valid,
  output logic                 res1_valid,
  output usd_pkg::usd_result_t res0,
  output usd_pkg::usd_result_t res1
);
  import usd_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // lead byte handling
  logic            st_res, st_err;
  logic [CP_W-1:0] st_cp;
  logic [2:0]      st_len;
  usd_state_t      st_state;

  // continuation handling
  logic            pending, is_cont, complete;
  logic [CP_W-1:0] cont_pv;
  logic [1:0]      cont_bs;

  logic            r0_err, r1_err;
  logic [CP_W-1:0] r0_cp, r1_cp;
  logic [2:0]      r0_len, r1_len;
  logic [COUNT_WIDTH-1:0] cnt1, cnt2;

  always_comb begin
    st_res   = 1'b0;
    st_err   = 1'b0;
    st_cp    = '0;
    st_len   = LEN_ERR;
    st_state = '0;
    if (!data_byte[7]) begin
      st_res = 1'b1;
      st_cp  = CP_W'(data_byte);
      st_len = LEN_1;
    end else if (data_byte[7:6] == 2'b10 || data_byte[7:3] == 5'b11111) begin
      st_res = 1'b1;
      st_err = 1'b1;
    end else if (last_byte) begin
      // lead byte cannot complete inside this buffer
      st_res = 1'b1;
      st_err = 1'b1;
    end else begin
      st_state.bytes_seen = 2'd1;
      if (!data_byte[5]) begin
        st_state.expected_len  = LEN_2;
        st_state.partial_value = CP_W'(data_byte[4:0]);
      end else if (!data_byte[4]) begin
        st_state.expected_len  = LEN_3;
        st_state.partial_value = CP_W'(data_byte[3:0]);
      end else begin
        st_state.expected_len  = LEN_4;
        st_state.partial_value = CP_W'(data_byte[2:0]);
      end
    end
  end

  assign pending  = (state.expected_len != LEN_ERR);
  assign is_cont  = (data_byte[7:6] == 2'b10);
  assign cont_pv  = {state.partial_value[CP_W-7:0], data_byte[5:0]};
  assign cont_bs  = state.bytes_seen + 2'd1;
  // four-byte sequences complete when the 2-bit seen count wraps
  assign complete = ({1'b0, cont_bs} == state.expected_len) ||
                    (state.expected_len == LEN_4 && cont_bs == 2'd0);

  always_comb begin
    state_next = state;
    res0_valid = 1'b0;
    res1_valid = 1'b0;
    r0_err     = 1'b0;
    r0_cp      = '0;
    r0_len     = LEN_ERR;
    r1_err     = 1'b0;
    r1_cp      = '0;
    r1_len     = LEN_ERR;
    if (pending && is_cont) begin
      if (complete) begin
        state_next = '0;
        res0_valid = 1'b1;
        r0_err     = !scalar_ok(cont_pv, state.expected_len);
        r0_cp      = cont_pv;
        r0_len     = state.expected_len;
      end else if (last_byte) begin
        state_next = '0;
        res0_valid = 1'b1;
        r0_err     = 1'b1;
      end else begin
        state_next.bytes_seen    = cont_bs;
        state_next.partial_value = cont_pv;
      end
    end else if (pending) begin
      // broken sequence, then restart on this byte
      state_next = st_state;
      res0_valid = 1'b1;
      r0_err     = 1'b1;
      res1_valid = st_res;
      r1_err     = st_err;
      r1_cp      = st_cp;
      r1_len     = st_len;
    end else begin
      state_next = st_state;
      res0_valid = st_res;
      r0_err     = st_err;
      r0_cp      = st_cp;
      r0_len     = st_len;
    end
  end

  assign cnt1 = (counter == CNT_MAX) ? counter : counter + COUNT_WIDTH'(1);
  assign cnt2 = (cnt1 == CNT_MAX) ? cnt1 : cnt1 + COUNT_WIDTH'(1);

  always_comb begin
    priority if (last_byte) counter_next = '0;
    else if (res1_valid)    counter_next = cnt2;
    else if (res0_valid)    counter_next = cnt1;
    else                    counter_next = counter;
  end

  assign res0.code_point = r0_err ? replacement_point : r0_cp;
  assign res0.seq_length = r0_err ? LEN_ERR : r0_len;
  assign res0.is_error   = r0_err;
  assign res0.char_index = 16'(cnt1);
  assign res1.code_point = r1_err ? replacement_point : r1_cp;
  assign res1.seq_length = r1_err ? LEN_ERR : r1_len;
  assign res1.is_error   = r1_err;
  assign res1.char_index = 16'(cnt2);

endmodule

`default_nettype wire

// File: rtl/usd_result_fifo.sv
// Three-entry result queue, two writes and one read per cycle; head is
// registered and drives the output channel. Depends on usd_pkg.
`default_nettype none

module usd_result_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push0,
  input  logic                 push1,
  input  usd_pkg::usd_result_t push_data0,
  input  usd_pkg::usd_result_t push_data1,
  input  logic                 out_ready,
  output logic                 out_valid,
  output usd_pkg::usd_result_t out_data,
  output logic                 room
);
  import usd_pkg::*;

  usd_result_t entries [3];
  usd_result_t entries_next [3];
  usd_result_t shifted [3];
  logic [1:0]  count, count_next, base;
  logic        pop;

  assign pop       = out_ready && (count != 2'd0);
  assign base      = count - {1'b0, pop};
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[0];
  // two free slots whatever the reader does this cycle
  assign room      = (count <= 2'd1);

  always_comb begin
    shifted[0] = pop ? entries[1] : entries[0];
    shifted[1] = pop ? entries[2] : entries[1];
    shifted[2] = entries[2];
    for (int i = 0; i < 3; i++) begin
      entries_next[i] = shifted[i];
      if (push0 && base == 2'(i))         entries_next[i] = push_data0;
      if (push1 && base + 2'd1 == 2'(i))  entries_next[i] = push_data1;
    end
    count_next = base + {1'b0, push0} + {1'b0, push1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      entries[i] <= entries_next[i];
    end
  end

`include "utf8_stream_decoder_top_assert.svh"

  `USD_ASSERT_IMPL(a_push1_needs_push0, push1, push0)
  `USD_ASSERT_IMPL(a_push_has_room, push0, count <= 2'd1)
  `USD_ASSERT_NEXT(a_head_held, out_valid && !out_ready, $stable(entries[0]))

endmodule

`default_nettype wire

// File: rtl/utf8_stream_decoder_top.sv
// UTF-8 stream decoder: up to one byte per cycle in, 0..2 results per byte out.
// Path: each accepted byte is held in the input register and decoded; its results are then
// registered in the result queue, whose head drives out_valid and the result outputs.
// Throughput: 1 byte/cycle while the queue has room; a byte giving two results can hold
// in_ready low while the 3-entry result queue drains, one result per cycle on out_ready.
// Reset (rst, synchronous): clears pending sequence, count, queue; replacement value 0xFFFD.
`default_nettype none

module utf8_stream_decoder_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [20:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] code_point,
  output logic [2:0]  seq_length,
  output logic        is_error,
  output logic [15:0] char_index
);
  import usd_pkg::*;

  logic [20:0] replacement_point;
  logic        ireg_valid;
  logic [7:0]  ireg_byte;
  logic        ireg_last;
  logic        room, consume;

  usd_state_t  state, state_next;
  logic [COUNT_WIDTH-1:0] counter, counter_next;
  logic        res0_valid, res1_valid;
  usd_result_t res0, res1, head;

  assign consume  = ireg_valid && room;
  assign in_ready = !ireg_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_point <= REPL_RESET;
    end else if (cfg_write_en) begin
      replacement_point <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      ireg_valid <= 1'b1;
    end else if (consume) begin
      ireg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ireg_byte <= data_byte;
      ireg_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= '0;
      counter <= '0;
    end else if (consume) begin
      state   <= state_next;
      counter <= counter_next;
    end
  end

  usd_decode #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_decode (
    .state            (state),
    .data_byte        (ireg_byte),
    .last_byte        (ireg_last),
    .counter          (counter),
    .replacement_point(replacement_point),
    .state_next       (state_next),
    .counter_next     (counter_next),
    .res0_valid       (res0_valid),
    .res1_valid       (res1_valid),
    .res0             (res0),
    .res1             (res1)
  );

  usd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (consume && res0_valid),
    .push1     (consume && res1_valid),
    .push_data0(res0),
    .push_data1(res1),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (head),
    .room      (room)
  );

  assign code_point = head.code_point;
  assign seq_length = head.seq_length;
  assign is_error   = head.is_error;
  assign char_index = head.char_index;

`include "utf8_stream_decoder_top_assert.svh"

  `USD_ASSERT_IMPL(a_idle_state_clear, state.expected_len == LEN_ERR,
                   state.bytes_seen == 2'd0 && state.partial_value == '0)
  `USD_ASSERT_IMPL(a_ok_has_length, out_valid && !is_error, seq_length != LEN_ERR)
  `USD_ASSERT_NEXT(a_count_cleared_at_end, consume && ireg_last, counter == '0)

endmodule

`default_nettype wire

// File: test/utf8_stream_decoder_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf8_stream_decoder_top: directed byte table, then random
// UTF-8 traffic under random stalls, checked against an in-bench decoder model.
// Depends on usd_pkg and the decoder RTL.

module utf8_stream_decoder_top_test;
  import usd_pkg::*;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    usd_result_t want;
  } stim_row_t;

  localparam usd_result_t UNCHECKED = '0;
  localparam logic [15:0] COUNT_SAT = 16'hFFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [20:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [20:0] code_point;
  logic [2:0]  seq_length;
  logic        is_error;
  logic [15:0] char_index;

  utf8_stream_decoder_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .code_point(code_point),
    .seq_length(seq_length),
    .is_error(is_error),
    .char_index(char_index)
  );

  always #5 clk = ~clk;

  // decoder model state
  logic [2:0]  pend_len = '0;
  logic [1:0]  pend_seen = '0;
  logic [20:0] pend_val = '0;
  logic [15:0] buf_chars = '0;
  logic [20:0] repl_value = REPL_RESET;
  usd_result_t decoded [2];
  int          decoded_n;

  usd_result_t expected_chars [$];
  int          mismatch_count = 0;
  int          sent_bytes = 0;
  bit          sender_idle = 1'b1;
  bit          receiver_idle = 1'b1;
  int          hold_off_cycles = 0;

  stim_row_t directed_rows [27] = '{
    {8'h00, 1'b0, 1'b1, 21'h000000, LEN_1, 1'b0, 16'd1},
    {8'h7F, 1'b0, 1'b1, 21'h00007F, LEN_1, 1'b0, 16'd2},
    {8'h80, 1'b0, 1'b1, REPL_RESET, LEN_ERR, 1'b1, 16'd3},   // stray continuation
    {8'hFF, 1'b0, 1'b1, REPL_RESET, LEN_ERR, 1'b1, 16'd4},   // bad lead
    {8'hC2, 1'b0, 1'b0, UNCHECKED},
    {8'hA9, 1'b0, 1'b0, UNCHECKED},
    {8'hC0, 1'b0, 1'b0, UNCHECKED},                          // overlong
    {8'h80, 1'b0, 1'b0, UNCHECKED},
    {8'hE2, 1'b0, 1'b0, UNCHECKED},
    {8'h82, 1'b0, 1'b0, UNCHECKED},
    {8'hAC, 1'b0, 1'b0, UNCHECKED},
    {8'hED, 1'b0, 1'b0, UNCHECKED},                          // surrogate
    {8'hA0, 1'b0, 1'b0, UNCHECKED},
    {8'h80, 1'b0, 1'b0, UNCHECKED},
    {8'hF4, 1'b0, 1'b0, UNCHECKED},                          // above max scalar
    {8'h90, 1'b0, 1'b0, UNCHECKED},
    {8'h80, 1'b0, 1'b0, UNCHECKED},
    {8'h80, 1'b0, 1'b0, UNCHECKED},
    {8'hF4, 1'b0, 1'b0, UNCHECKED},                          // max scalar
    {8'h8F, 1'b0, 1'b0, UNCHECKED},
    {8'hBF, 1'b0, 1'b0, UNCHECKED},
    {8'hBF, 1'b0, 1'b0, UNCHECKED},
    {8'hE0, 1'b0, 1'b0, UNCHECKED},                          // broken: two results
    {8'h41, 1'b0, 1'b0, UNCHECKED},
    {8'hE2, 1'b0, 1'b0, UNCHECKED},                          // cut off by end of buffer
    {8'h82, 1'b1, 1'b0, UNCHECKED},
    {8'hC3, 1'b1, 1'b1, REPL_RESET, LEN_ERR, 1'b1, 16'd1}    // lead on last byte
  };

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40)
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic range_ok(input logic [20:0] v, input logic [2:0] len);
    case (len)
      LEN_2:   return v > MAX_2BYTE;
      LEN_3:   return (v > MAX_3BYTE) && !((v >= SURR_LO) && (v <= SURR_HI));
      default: return (v > MAX_BMP) && (v <= MAX_SCALAR);
    endcase
  endfunction

  task automatic emit_char(input logic [20:0] cp, input logic [2:0] len, input logic err);
    usd_result_t r;
    if (buf_chars != COUNT_SAT)
      buf_chars++;
    r.code_point = err ? repl_value : cp;
    r.seq_length = err ? LEN_ERR : len;
    r.is_error   = err;
    r.char_index = buf_chars;
    decoded[decoded_n] = r;
    decoded_n++;
  endtask

  task automatic clear_pending();
    pend_len  = '0;
    pend_seen = '0;
    pend_val  = '0;
  endtask

  task automatic lead_byte(input logic [7:0] b, input logic lst);
    if (b < 8'h80) begin
      emit_char({13'd0, b}, LEN_1, 1'b0);
    end else if (b < 8'hC0 || b >= 8'hF8) begin
      emit_char('0, LEN_ERR, 1'b1);
    end else begin
      if (b < 8'hE0) begin
        pend_len = LEN_2;
        pend_val = {16'd0, b[4:0]};
      end else if (b < 8'hF0) begin
        pend_len = LEN_3;
        pend_val = {17'd0, b[3:0]};
      end else begin
        pend_len = LEN_4;
        pend_val = {18'd0, b[2:0]};
      end
      pend_seen = 2'd1;
      if (lst) begin
        clear_pending();
        emit_char('0, LEN_ERR, 1'b1);
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic lst);
    logic [20:0] v;
    logic [2:0]  n;
    logic        done;
    decoded_n = 0;
    if (pend_len != 3'd0) begin
      if (b[7:6] == 2'b10) begin
        pend_val  = {pend_val[14:0], b[5:0]};
        pend_seen = pend_seen + 2'd1;
        // a four-byte sequence wraps the 2-bit seen count to zero
        done = ({1'b0, pend_seen} == pend_len) || (pend_len == LEN_4 && pend_seen == 2'd0);
        if (done) begin
          v = pend_val;
          n = pend_len;
          clear_pending();
          if (range_ok(v, n))
            emit_char(v, n, 1'b0);
          else
            emit_char('0, LEN_ERR, 1'b1);
        end else if (lst) begin
          clear_pending();
          emit_char('0, LEN_ERR, 1'b1);
        end
      end else begin
        clear_pending();
        emit_char('0, LEN_ERR, 1'b1);
        lead_byte(b, lst);
      end
    end else begin
      lead_byte(b, lst);
    end
    if (lst)
      buf_chars = '0;
  endtask

  // offer one byte, hold it until taken, then queue what it should produce
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input usd_result_t want);
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
    decode_byte(b, lst);
    if (typed) begin
      expected_chars.push_back(want);
    end else begin
      for (int i = 0; i < decoded_n; i++)
        expected_chars.push_back(decoded[i]);
    end
    if (sender_idle && $urandom_range(0, 15) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    // lead bytes give no result, so let the pipe settle before touching config
    repeat (6) @(posedge clk);
  endtask

  task automatic set_replacement(input logic [20:0] v);
    cfg_write_data <= v;
    cfg_write_en   <= 1'b1;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    repl_value = v;
  endtask

  function automatic logic [31:0] encode_utf8(input logic [20:0] v, input int n);
    case (n)
      1:       return {v[7:0], 24'd0};
      2:       return {3'b110, v[10:6], 2'b10, v[5:0], 16'd0};
      3:       return {4'b1110, v[15:12], 2'b10, v[11:6], 2'b10, v[5:0], 8'd0};
      default: return {5'b11110, v[20:18], 2'b10, v[17:12], 2'b10, v[11:6], 2'b10, v[5:0]};
    endcase
  endfunction

  function automatic logic [20:0] valid_scalar(input int n);
    logic [20:0] v;
    case (n)
      1: v = 21'($urandom_range(0, 'h7F));
      2: v = 21'($urandom_range('h80, 'h7FF));
      3: begin
        v = 21'($urandom_range('h800, 'hFFFF));
        if (v >= SURR_LO && v <= SURR_HI)
          v = v ^ 21'h1000;
      end
      default: v = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return v;
  endfunction

  task automatic send_random_char();
    logic [20:0] edge_vals [14];
    logic [31:0] seq_bytes;
    logic [20:0] v;
    int          kind;
    int          n;
    edge_vals = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF, 21'hD800, 21'hDFFF,
                  21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF, 21'h110000, 21'h1FFFFF};
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      n = $urandom_range(1, 4);
      seq_bytes = encode_utf8(valid_scalar(n), n);
    end else if (kind < 60) begin
      v = edge_vals[$urandom_range(0, 13)];
      n = (v < 21'h80) ? 1 : (v < 21'h800) ? 2 : (v < 21'h10000) ? 3 : 4;
      seq_bytes = encode_utf8(v, n);
    end else if (kind < 75) begin
      // well-formed shape, arbitrary payload bits: hits overlong and range errors
      n = $urandom_range(2, 4);
      seq_bytes = $urandom & 32'h3F3F3F3F | 32'h80808080;
      case (n)
        2:       seq_bytes[31:24] = 8'hC0 | 8'($urandom_range(0, 31));
        3:       seq_bytes[31:24] = 8'hE0 | 8'($urandom_range(0, 15));
        default: seq_bytes[31:24] = 8'hF0 | 8'($urandom_range(0, 7));
      endcase
    end else if (kind < 88) begin
      n = $urandom_range(2, 4);
      seq_bytes = encode_utf8(valid_scalar(n), n);
      n = $urandom_range(1, n - 1);
    end else begin
      n = 1;
      seq_bytes = {8'($urandom_range(0, 255)), 24'd0};
    end
    for (int i = 0; i < n; i++)
      send_byte(seq_bytes[31 - 8 * i -: 8], $urandom_range(0, 29) == 0, 1'b0, UNCHECKED);
  endtask

  task automatic run_random(input int nbytes);
    int target;
    target = sent_bytes + nbytes;
    while (sent_bytes < target)
      send_random_char();
  endtask

  // receiver: random stall bursts plus a long requested hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
        out_ready <= 1'b1;
      end else if (receiver_idle && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    usd_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("result with none expected, code_point", 32'(code_point), 32'd0);
      end else begin
        want = expected_chars.pop_front();
        if (code_point !== want.code_point)
          report_mismatch("code_point", 32'(code_point), 32'(want.code_point));
        if (seq_length !== want.seq_length)
          report_mismatch("seq_length", 32'(seq_length), 32'(want.seq_length));
        if (is_error !== want.is_error)
          report_mismatch("is_error", 32'(is_error), 32'(want.is_error));
        if (char_index !== want.char_index)
          report_mismatch("char_index", 32'(char_index), 32'(want.char_index));
      end
    end
  end

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);

    wait_drained();
    set_replacement(21'h000000);
    hold_off_cycles = 300;   // input side must back up behind the stalled output
    run_random(350);

    wait_drained();
    set_replacement(MAX_SCALAR);
    run_random(350);

    // short buffer starting with a bad lead and ending in an ASCII byte, random replacement value
    wait_drained();
    set_replacement(21'($urandom_range(0, 'h10FFFF)));
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    send_byte(8'hFF, 1'b0, 1'b0, UNCHECKED);
    send_byte(8'h41, 1'b1, 1'b0, UNCHECKED);

    wait_drained();
    set_replacement(REPL_RESET);
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    run_random(400);

    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    run_random(400);

    in_valid <= 1'b0;
    waited = 0;
    while (expected_chars.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_chars.size() != 0)
      report_mismatch("results never produced, count", 32'(expected_chars.size()), 32'd0);

    if (mismatch_count == 0)
      $display("PASS utf8_stream_decoder_top");
    else
      $display("FAIL utf8_stream_decoder_top");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL utf8_stream_decoder_top");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/usd_pkg.sv
rtl/usd_decode.sv
rtl/usd_result_fifo.sv
rtl/utf8_stream_decoder_top.sv
test/utf8_stream_decoder_top_test.sv
